FILE: sv/trico_pkg.sv
// ----------------------------------------------------------------------------
// trico_pkg
// Shared types, widths and the microcode table of the trinomial
// coefficient unit.
// ----------------------------------------------------------------------------
package trico_pkg;

   localparam int unsigned FieldWidth = 5;
   localparam int unsigned CoefWidth  = 21;
   localparam int unsigned ProdWidth  = 26;
   localparam int unsigned StepWidth  = 4;

   typedef struct packed {
      logic [FieldWidth-1:0] order_n;
      logic [FieldWidth-1:0] part_two;
      logic [FieldWidth-1:0] part_three;
   } req_type;

   typedef struct packed {
      logic [CoefWidth-1:0] coefficient;
      logic                 invalid;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_LOAD,
      OP_MUL_A,
      OP_MUL_B,
      OP_DIV_START,
      OP_UPDATE,
      OP_REINIT,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_INVALID,
      COND_I_GT_P2,
      COND_I_GT_P3,
      COND_DIV_BUSY,
      COND_RSP_BLOCKED
   } cond_type;

   typedef logic [StepWidth-1:0] step_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ucode_type;

   localparam step_type STEP_IDLE    = 4'd0;
   localparam step_type STEP_CHECK   = 4'd1;
   localparam step_type STEP_TEST_A  = 4'd2;
   localparam step_type STEP_MUL_A   = 4'd3;
   localparam step_type STEP_START_A = 4'd4;
   localparam step_type STEP_WAIT_A  = 4'd5;
   localparam step_type STEP_UPD_A   = 4'd6;
   localparam step_type STEP_REINIT  = 4'd7;
   localparam step_type STEP_TEST_B  = 4'd8;
   localparam step_type STEP_MUL_B   = 4'd9;
   localparam step_type STEP_START_B = 4'd10;
   localparam step_type STEP_WAIT_B  = 4'd11;
   localparam step_type STEP_UPD_B   = 4'd12;
   localparam step_type STEP_EMIT    = 4'd13;
   localparam step_type STEP_RETURN  = 4'd14;
   localparam step_type STEP_SPARE   = 4'd15;

   // jump to target when the condition holds, otherwise fall through
   function automatic ucode_type ucode_rom(step_type step);
      ucode_type word;
      unique case (step)
         STEP_IDLE:    word = '{OP_LOAD,      COND_NO_REQ,      STEP_IDLE};
         STEP_CHECK:   word = '{OP_NOP,       COND_INVALID,     STEP_EMIT};
         STEP_TEST_A:  word = '{OP_NOP,       COND_I_GT_P2,     STEP_REINIT};
         STEP_MUL_A:   word = '{OP_MUL_A,     COND_NEVER,       STEP_IDLE};
         STEP_START_A: word = '{OP_DIV_START, COND_NEVER,       STEP_IDLE};
         STEP_WAIT_A:  word = '{OP_NOP,       COND_DIV_BUSY,    STEP_WAIT_A};
         STEP_UPD_A:   word = '{OP_UPDATE,    COND_ALWAYS,      STEP_TEST_A};
         STEP_REINIT:  word = '{OP_REINIT,    COND_NEVER,       STEP_IDLE};
         STEP_TEST_B:  word = '{OP_NOP,       COND_I_GT_P3,     STEP_EMIT};
         STEP_MUL_B:   word = '{OP_MUL_B,     COND_NEVER,       STEP_IDLE};
         STEP_START_B: word = '{OP_DIV_START, COND_NEVER,       STEP_IDLE};
         STEP_WAIT_B:  word = '{OP_NOP,       COND_DIV_BUSY,    STEP_WAIT_B};
         STEP_UPD_B:   word = '{OP_UPDATE,    COND_ALWAYS,      STEP_TEST_B};
         STEP_EMIT:    word = '{OP_EMIT,      COND_RSP_BLOCKED, STEP_EMIT};
         STEP_RETURN:  word = '{OP_NOP,       COND_ALWAYS,      STEP_IDLE};
         default:      word = '{OP_NOP,       COND_ALWAYS,      STEP_IDLE};
      endcase
      return word;
   endfunction

endpackage

FILE: sv/trico_div.sv
// ----------------------------------------------------------------------------
// trico_div
// Restoring divider for the exact-divide steps: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module trico_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [trico_pkg::ProdWidth-1:0]    dividend,
   input  logic [trico_pkg::FieldWidth-1:0]   divisor,
   output logic                               busy,
   output logic [trico_pkg::ProdWidth-1:0]    quotient
);

   localparam int unsigned CountWidth = $clog2(trico_pkg::ProdWidth + 1);
   localparam int unsigned DW         = trico_pkg::FieldWidth;
   localparam int unsigned QW         = trico_pkg::ProdWidth;

   logic                  busy_ff;
   logic                  busy_in;
   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;
   logic [DW-1:0]         rem_ff;
   logic [DW-1:0]         rem_in;
   logic [QW-1:0]         quo_ff;
   logic [QW-1:0]         quo_in;
   logic [DW-1:0]         dsr_ff;
   logic [DW:0]           trial;
   logic [DW:0]           diff;
   logic                  fits;

   always_comb begin
      trial = {rem_ff, quo_ff[QW-1]};
      diff  = trial - {1'b0, dsr_ff};
      fits  = (trial >= {1'b0, dsr_ff});
      rem_in = fits ? diff[DW-1:0] : trial[DW-1:0];
      quo_in = {quo_ff[QW-2:0], fits};
      busy_in  = busy_ff;
      count_in = count_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CountWidth'(QW);
      end else if (busy_ff) begin
         count_in = count_ff - 1'b1;
         if (count_ff == CountWidth'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

FILE: sv/trinomial_coefficient.sv
// ----------------------------------------------------------------------------
// trinomial_coefficient
// Three-part multinomial coefficient n!/(k1!k2!k3!) with k1 = n - k2 - k3.
// ----------------------------------------------------------------------------
// One transaction at a time. The parts are sorted so that k1 >= k2 >= k3 and
// the coefficient is built as C(n,k2) * C(n-k2,k3) by a microcoded sequencer
// that runs multiply then exact-divide steps on a shared restoring divider.
// A rejected transaction (k2 + k3 > n, or n > MAX_ORDER) returns coefficient
// 0 with invalid set. The result sits in an output register, so the next
// transaction is taken while the previous result waits.
// ----------------------------------------------------------------------------
module trinomial_coefficient #(
   parameter int unsigned MAX_ORDER = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  trico_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output trico_pkg::rsp_type  rsp_data
);

   localparam int unsigned FW = trico_pkg::FieldWidth;
   localparam int unsigned CW = trico_pkg::CoefWidth;
   localparam int unsigned PW = trico_pkg::ProdWidth;
   localparam logic [FW-1:0] MaxN = FW'(MAX_ORDER);

   trico_pkg::step_type  step_ff;
   trico_pkg::step_type  step_in;
   trico_pkg::ucode_type uword;
   logic                 cond_true;

   logic [FW-1:0] n_ff;
   logic [FW-1:0] p2_ff;
   logic [FW-1:0] p3_ff;
   logic          invalid_ff;
   logic [FW-1:0] i_ff;
   logic [CW-1:0] acc_ff;
   logic [PW-1:0] prod_ff;
   trico_pkg::rsp_type rsp_ff;
   logic          rsp_valid_ff;

   logic [FW-1:0] s1;
   logic [FW-1:0] s2;
   logic [FW-1:0] s3;
   logic [FW-1:0] tmp;
   logic [FW:0]   part_sum;
   logic          req_invalid;
   logic [FW-1:0] base;
   logic [FW-1:0] factor;
   logic          rsp_blocked;
   logic          div_start;
   logic          div_busy;
   logic [PW-1:0] div_quotient;

   always_comb begin
      tmp = '0;
      s1 = req_data.order_n - req_data.part_two - req_data.part_three;
      s2 = req_data.part_two;
      s3 = req_data.part_three;
      if (s2 > s1) begin
         tmp = s1; s1 = s2; s2 = tmp;
      end
      if (s3 > s2) begin
         tmp = s2; s2 = s3; s3 = tmp;
      end
      if (s2 > s1) begin
         tmp = s1; s1 = s2; s2 = tmp;
      end
      part_sum    = {1'b0, req_data.part_two} + {1'b0, req_data.part_three};
      req_invalid = (req_data.order_n > MaxN) || (part_sum > {1'b0, req_data.order_n});
   end

   assign uword       = trico_pkg::ucode_rom(step_ff);
   assign rsp_blocked = rsp_valid_ff && !rsp_ready;
   assign base        = (uword.op == trico_pkg::OP_MUL_B) ? (n_ff - p2_ff) : n_ff;
   assign factor      = base + FW'(1) - i_ff;
   assign div_start   = (uword.op == trico_pkg::OP_DIV_START);

   always_comb begin
      unique case (uword.cond)
         trico_pkg::COND_NEVER:       cond_true = 1'b0;
         trico_pkg::COND_ALWAYS:      cond_true = 1'b1;
         trico_pkg::COND_NO_REQ:      cond_true = !req_valid;
         trico_pkg::COND_INVALID:     cond_true = invalid_ff;
         trico_pkg::COND_I_GT_P2:     cond_true = (i_ff > p2_ff);
         trico_pkg::COND_I_GT_P3:     cond_true = (i_ff > p3_ff);
         trico_pkg::COND_DIV_BUSY:    cond_true = div_busy;
         trico_pkg::COND_RSP_BLOCKED: cond_true = rsp_blocked;
         default:                     cond_true = 1'b1;
      endcase
      step_in = cond_true ? uword.target : step_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= trico_pkg::STEP_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         if (uword.op == trico_pkg::OP_EMIT && !rsp_blocked) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (uword.op)
         trico_pkg::OP_LOAD: begin
            if (req_valid) begin
               n_ff       <= req_data.order_n;
               p2_ff      <= s2;
               p3_ff      <= s3;
               invalid_ff <= req_invalid;
               acc_ff     <= CW'(1);
               i_ff       <= FW'(1);
            end
         end
         trico_pkg::OP_MUL_A, trico_pkg::OP_MUL_B: begin
            prod_ff <= PW'(acc_ff) * PW'(factor);
         end
         trico_pkg::OP_UPDATE: begin
            acc_ff <= div_quotient[CW-1:0];
            i_ff   <= i_ff + 1'b1;
         end
         trico_pkg::OP_REINIT: begin
            i_ff <= FW'(1);
         end
         trico_pkg::OP_EMIT: begin
            if (!rsp_blocked) begin
               rsp_ff.coefficient <= invalid_ff ? '0 : acc_ff;
               rsp_ff.invalid     <= invalid_ff;
            end
         end
         default: begin
         end
      endcase
   end

   trico_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (i_ff),
      .busy     (div_busy),
      .quotient (div_quotient)
   );

   assign req_ready = (step_ff == trico_pkg::STEP_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: dv/tb_trinomial_coefficient.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_trinomial_coefficient
// Self-checking bench for the three-part multinomial coefficient unit.
// ----------------------------------------------------------------------------
// A directed set covers zero parts, the largest coefficient, full and empty
// parts in every position, rejected orders and parts that exceed the order.
// Random items follow: mostly well-formed (k2 + k3 <= n <= 16), the rest raw
// 5-bit fields. Both channels idle at random, the receiver holds off once for
// a long stretch so the input stalls, and the sender twice waits until every
// pending result has come back. Each result is checked against a predictor of
// n!/(k1!k2!k3!) built from sorted multiply and exact-divide loops.
// ----------------------------------------------------------------------------
module tb_trinomial_coefficient;

   localparam int unsigned MaxOrder     = 16;
   localparam int unsigned RandomItems  = 1130;
   localparam int unsigned FirstDrain   = 25;
   localparam int unsigned SecondDrain  = 700;
   localparam int unsigned LongStallAt  = 300;
   localparam int unsigned LongStall    = 2500;
   localparam int unsigned SettleCycles = 600;
   localparam int unsigned CycleLimit   = 3000000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   trico_pkg::req_type req_data = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   trico_pkg::rsp_type rsp_data;

   trico_pkg::req_type pending_items[$];
   trico_pkg::rsp_type expected_results[$];
   int unsigned taken_count = 0;
   int unsigned checked_count = 0;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned send_gap = 0;
   int unsigned send_wait;
   int unsigned recv_gap = 0;
   int unsigned recv_wait;
   trico_pkg::rsp_type want;

   trinomial_coefficient #(
      .MAX_ORDER(MaxOrder)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic trico_pkg::rsp_type trinomial_of(trico_pkg::req_type item);
      trico_pkg::rsp_type result;
      int unsigned     n;
      int unsigned     big;
      int unsigned     mid;
      int unsigned     low;
      int unsigned     swap;
      longint unsigned acc;
      result = '0;
      n   = item.order_n;
      mid = item.part_two;
      low = item.part_three;
      if (n > MaxOrder || mid + low > n) begin
         result.invalid = 1'b1;
         return result;
      end
      big = n - mid - low;
      if (mid > big) begin
         swap = big; big = mid; mid = swap;
      end
      if (low > mid) begin
         swap = mid; mid = low; low = swap;
      end
      if (mid > big) begin
         swap = big; big = mid; mid = swap;
      end
      acc = 1;
      for (int unsigned i = 1; i <= mid; i++)
         acc = acc * (n - i + 1) / i;
      for (int unsigned i = 1; i <= low; i++)
         acc = acc * (n - mid - i + 1) / i;
      result.coefficient = acc[trico_pkg::CoefWidth-1:0];
      return result;
   endfunction

   // alternate idle phases with bursts of back-to-back traffic
   function automatic int unsigned idle_gap(int unsigned index);
      if ((index / 64) % 3 == 2)
         return 0;
      return $urandom_range(0, 10);
   endfunction

   task automatic add_item(int unsigned n, int unsigned k2, int unsigned k3);
      trico_pkg::req_type item;
      item.order_n    = n[trico_pkg::FieldWidth-1:0];
      item.part_two   = k2[trico_pkg::FieldWidth-1:0];
      item.part_three = k3[trico_pkg::FieldWidth-1:0];
      pending_items.push_back(item);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            expected_results.push_back(trinomial_of(req_data));
            taken_count = taken_count + 1;
            send_wait = idle_gap(taken_count);
         end else begin
            send_wait = send_gap;
         end
         if (send_wait == 0 && pending_items.size() != 0 &&
             !((taken_count == FirstDrain || taken_count == SecondDrain) &&
               checked_count != taken_count)) begin
            req_data  <= pending_items.pop_front();
            req_valid <= 1'b1;
            send_gap  <= 0;
         end else begin
            req_valid <= 1'b0;
            send_gap  <= (send_wait == 0) ? 0 : send_wait - 1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap  <= 0;
      end else if (rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result coefficient %0d invalid %0b",
                     $time, rsp_data.coefficient, rsp_data.invalid);
            error_count <= error_count + 1;
         end else begin
            want = expected_results.pop_front();
            if (rsp_data.coefficient !== want.coefficient ||
                rsp_data.invalid !== want.invalid) begin
               if (rsp_data.coefficient !== want.coefficient)
                  $display("%0t: coefficient expected %0d actual %0d", $time,
                           want.coefficient, rsp_data.coefficient);
               if (rsp_data.invalid !== want.invalid)
                  $display("%0t: invalid expected %0b actual %0b", $time,
                           want.invalid, rsp_data.invalid);
               error_count <= error_count + 1;
            end
         end
         checked_count <= checked_count + 1;
         recv_wait = (checked_count + 1 == LongStallAt) ? LongStall
                                                         : idle_gap(checked_count);
         if (recv_wait != 0) begin
            rsp_ready <= 1'b0;
            recv_gap  <= recv_wait - 1;
         end
      end else if (!rsp_ready) begin
         if (recv_gap == 0)
            rsp_ready <= 1'b1;
         else
            recv_gap <= recv_gap - 1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      int unsigned n;
      int unsigned k2;
      add_item(0, 0, 0);
      add_item(16, 0, 0);
      add_item(16, 5, 5);
      add_item(16, 6, 5);
      add_item(16, 5, 6);
      add_item(16, 16, 0);
      add_item(16, 0, 16);
      add_item(16, 8, 8);
      add_item(16, 1, 15);
      add_item(1, 1, 0);
      add_item(1, 0, 1);
      add_item(7, 0, 7);
      add_item(9, 1, 4);
      add_item(9, 4, 1);
      add_item(12, 4, 4);
      add_item(17, 0, 0);
      add_item(31, 0, 0);
      add_item(31, 31, 31);
      add_item(0, 1, 0);
      add_item(0, 0, 1);
      add_item(5, 3, 3);
      add_item(16, 16, 1);
      add_item(16, 16, 16);
      add_item(10, 31, 0);
      add_item(15, 0, 16);
      for (int unsigned i = 0; i < RandomItems; i++) begin
         if ($urandom_range(0, 3) != 0) begin
            n  = $urandom_range(0, MaxOrder);
            k2 = $urandom_range(0, n);
            add_item(n, k2, $urandom_range(0, n - k2));
         end else begin
            add_item($urandom_range(0, 31), $urandom_range(0, 31),
                     $urandom_range(0, 31));
         end
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      while (pending_items.size() != 0 || req_valid || checked_count != taken_count)
         @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
      if (error_count == 0 && expected_results.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
